/* hdl/rpmc_pkg.sv */
// Package for the rotated pattern match counter.
// Holds sizes, request codes, state type and the payload structs; no dependencies.
package rpmc_pkg;
   localparam int MaxImage   = 64;
   localparam int MaxPattern = 16;
   localparam int ImgAw      = $clog2(MaxImage * MaxImage);
   localparam int PatAw      = $clog2(MaxPattern * MaxPattern);
   localparam int ImgIw      = $clog2(MaxImage);
   localparam int PatIw      = $clog2(MaxPattern);
   localparam logic [12:0] CountMax = 13'd8191;

   typedef enum logic [1:0] {
      REQ_LOAD_IMAGE   = 2'd0,
      REQ_LOAD_PATTERN = 2'd1,
      REQ_RUN          = 2'd2,
      REQ_UNUSED       = 2'd3
   } req_code_type;

   localparam logic CsrImageSize   = 1'b0;
   localparam logic CsrPatternSize = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CMP, ST_NEXT, ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] row;
      logic [5:0] col;
      logic [7:0] cell_value;
   } req_type_type;

   typedef struct packed {
      logic [12:0] count_rot0;
      logic [12:0] count_rot90;
      logic [12:0] count_rot180;
      logic [12:0] count_rot270;
   } rsp_type;
endpackage

/* hdl/rotated_pattern_match_counter_top.sv */
// Rotated pattern match counter: loads image and pattern stores and counts matches.
// Depends on rpmc_pkg and rpmc_ram.
//
// Usage. Items enter on req_ with start; an item is taken when start is high and
// busy is low. Image and pattern loads give no result, so while the block is idle
// loads stream at one beat per cycle. A run request raises busy while the scan
// walks the stores; one result beat then appears on rsp_ with rsp_valid high for
// exactly one cycle, and the receiver cannot stall it.
// Run sequence: for each position and rotation, the cells are compared one at a
// time, each with a memory read state then a compare state, stopping at the first
// mismatch, then a step state moves on to the next position/rotation. The run time
// is set by the single read port of each store. The store contents are undefined
// after reset; reset returns the state machine to idle and sets image_size to 64
// and pattern_size to 1. Configuration must be written via csr_ only while the
// block is idle; the block does not enforce this.
module rotated_pattern_match_counter_top
   import rpmc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [6:0]   csr_wr_data
);
   logic [6:0] img_size_ff;
   logic [4:0] pat_size_ff;
   state_type  state_ff, state_in;
   logic [6:0] x_ff, x_in, y_ff, y_in;
   logic [4:0] i_ff, i_in, j_ff, j_in;
   logic [1:0] rot_ff, rot_in;
   logic [12:0] cnt_ff [4];
   logic [12:0] cnt_in [4];
   logic [6:0] n, lim;
   logic [4:0] m, mm1;
   logic       accept;
   logic       img_we, pat_we;
   logic [ImgAw-1:0] img_wa, img_ra;
   logic [PatAw-1:0] pat_wa, pat_ra;
   logic [7:0] img_rd, pat_rd;
   logic [4:0] pr, pc;
   logic [6:0] ir, ic;
   logic       last_cell;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_size_ff <= 7'd64;
         pat_size_ff <= 5'd1;
      end else if (csr_wr_en) begin
         if (csr_index == CsrImageSize) begin
            img_size_ff <= csr_wr_data;
         end else begin
            pat_size_ff <= csr_wr_data[4:0];
         end
      end
   end

   assign n   = (img_size_ff > 7'(MaxImage)) ? 7'(MaxImage) : img_size_ff;
   assign m   = (pat_size_ff > 5'(MaxPattern)) ? 5'(MaxPattern) : pat_size_ff;
   assign mm1 = m - 5'd1;
   assign lim = n - 7'(m);  // last valid origin
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign img_we = accept && (req_data.req_type == REQ_LOAD_IMAGE);
   assign pat_we = accept && (req_data.req_type == REQ_LOAD_PATTERN)
                   && (req_data.row < 6'(MaxPattern)) && (req_data.col < 6'(MaxPattern));
   assign img_wa = {req_data.row[ImgIw-1:0], req_data.col[ImgIw-1:0]};
   assign pat_wa = {req_data.row[PatIw-1:0], req_data.col[PatIw-1:0]};

   // Rotation is applied to the pattern read address.
   always_comb begin
      case (rot_ff)
         2'd0:    begin pr = i_ff;       pc = j_ff;       end
         2'd1:    begin pr = mm1 - j_ff; pc = i_ff;       end
         2'd2:    begin pr = mm1 - i_ff; pc = mm1 - j_ff; end
         default: begin pr = j_ff;       pc = mm1 - i_ff; end
      endcase
   end
   assign ir = x_ff + 7'(i_ff);
   assign ic = y_ff + 7'(j_ff);
   assign img_ra = {ir[ImgIw-1:0], ic[ImgIw-1:0]};
   assign pat_ra = {pr[PatIw-1:0], pc[PatIw-1:0]};
   assign last_cell = (i_ff == mm1) && (j_ff == mm1);

   rpmc_ram #(.Width(8), .Depth(MaxImage * MaxImage)) u_img (
      .clock, .wr_en(img_we), .wr_addr(img_wa), .wr_data(req_data.cell_value),
      .rd_addr(img_ra), .rd_data(img_rd));
   rpmc_ram #(.Width(8), .Depth(MaxPattern * MaxPattern)) u_pat (
      .clock, .wr_en(pat_we), .wr_addr(pat_wa), .wr_data(req_data.cell_value),
      .rd_addr(pat_ra), .rd_data(pat_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in; y_ff <= y_in; i_ff <= i_in; j_ff <= j_in; rot_ff <= rot_in;
      for (int k = 0; k < 4; k++) cnt_ff[k] <= cnt_in[k];
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; i_in = i_ff; j_in = j_ff; rot_in = rot_ff;
      for (int k = 0; k < 4; k++) cnt_in[k] = cnt_ff[k];
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.req_type == REQ_RUN) begin
               x_in = '0; y_in = '0; i_in = '0; j_in = '0; rot_in = '0;
               for (int k = 0; k < 4; k++) cnt_in[k] = '0;
               if (n == 7'd0 || m == 5'd0 || 7'(m) > n) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_CMP;
         ST_CMP: begin
            if (img_rd != pat_rd) begin
               state_in = ST_NEXT;
            end else if (last_cell) begin
               if (cnt_ff[rot_ff] != CountMax) begin
                  cnt_in[rot_ff] = cnt_ff[rot_ff] + 13'd1;
               end
               state_in = ST_NEXT;
            end else begin
               if (j_ff == mm1) begin
                  j_in = '0;
                  i_in = i_ff + 5'd1;
               end else begin
                  j_in = j_ff + 5'd1;
               end
               state_in = ST_READ;
            end
         end
         ST_NEXT: begin
            i_in = '0; j_in = '0;
            state_in = ST_READ;
            rot_in = rot_ff + 2'd1;
            if (rot_ff == 2'd3) begin
               if (y_ff == lim) begin
                  y_in = '0;
                  if (x_ff == lim) begin
                     state_in = ST_DONE;
                  end else begin
                     x_in = x_ff + 7'd1;
                  end
               end else begin
                  y_in = y_ff + 7'd1;
               end
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data.count_rot0   = cnt_ff[0];
   assign rsp_data.count_rot90  = cnt_ff[1];
   assign rsp_data.count_rot180 = cnt_ff[2];
   assign rsp_data.count_rot270 = cnt_ff[3];

   // A result beat is always followed by the block returning to idle with rsp_valid low.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result not followed by idle");
   // A run request makes the block busy in the next cycle.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type == REQ_RUN) |=> busy)
      else $error("run did not start");
   // Loads never leave the block busy.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type != REQ_RUN) |=> !busy)
      else $error("load made the block busy");
endmodule

/* hdl/rpmc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rpmc_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
